>>> hdl/kmrb_pkg.sv
package kmrb_pkg;

  localparam int ROWS_DEF   = 8;
  localparam int COLS_DEF   = 8;
  localparam int SLOTS_DEF  = 6;
  localparam int LAYERS_DEF = 4;

  localparam int KEY_FIELDS = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic REG_LOWER_ADD = 1'b0;
  localparam logic REG_RAISE_ADD = 1'b1;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_SCAN  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic        action;
    logic [1:0]  map_layer;
    logic [2:0]  map_row;
    logic [2:0]  col_index;
    logic [15:0] entry_code;
    logic [7:0]  row_bits;
    logic        lower_held;
    logic        raise_held;
    logic        first_column;
    logic        last_column;
  } in_item_t;

  typedef struct packed {
    logic [7:0] modifiers;
    logic [7:0] key_0;
    logic [7:0] key_1;
    logic [7:0] key_2;
    logic [7:0] key_3;
    logic [7:0] key_4;
    logic [7:0] key_5;
  } out_item_t;

  typedef struct packed {
    logic [1:0] lower_add;
    logic [1:0] raise_add;
  } cfg_t;

  // classified command between front and back
  typedef struct packed {
    cmd_e        cmd;
    logic        wen;
    logic [1:0]  layer;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [15:0] code;
    logic [7:0]  mask;
    logic        first;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
  } front_stat_t;

  typedef struct packed {
    logic pop;
    logic emit;
    logic busy;
  } back_stat_t;

  function automatic logic [7:0] map_index(input logic [1:0] layer, input logic [2:0] row,
                                           input logic [2:0] col, input int rows,
                                           input int cols);
    int idx;
    idx = (int'(layer) * rows + int'(row)) * cols + int'(col);
    return idx[7:0];
  endfunction

endpackage

>>> hdl/key_matrix_report_builder.sv
// Keyboard report builder for a scanned key matrix.
// Input channel (in_valid_i / in_stall_o, in_item_i): an item either writes one
// keymap entry (action 0) or brings the pressed rows of one scanned column
// (action 1). A two-entry command queue sits behind the input, so stall rises
// only when both entries are waiting.
// Output channel (out_valid_o / out_stall_i, out_item_o): one report per scan
// item marked last_column, holding the modifiers and six key slots.
// A write item is handled by the sequencer in its idle state. A scan item passes
// through a load in the idle state, the row walk (one keymap read per pressed row
// from the single-port store) and a drain state, plus an emit state when it is
// marked last_column. The row walk sets the sustained rate.
// While the receiver stalls, the report holds in the output register; the
// next report waits in the sequencer and the queue keeps taking items until full.
// Reset clears the queue, the slots, modifiers and latched layer; the offsets
// return to 1 (lower) and 2 (raise). The keymap is not cleared and must be
// written before it is scanned.
// The APB port holds the offsets at byte addresses 0 (lower) and 4 (raise).
module key_matrix_report_builder #(
  parameter int ROWS   = kmrb_pkg::ROWS_DEF,
  parameter int COLS   = kmrb_pkg::COLS_DEF,
  parameter int SLOTS  = kmrb_pkg::SLOTS_DEF,
  parameter int LAYERS = kmrb_pkg::LAYERS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kmrb_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kmrb_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  kmrb_pkg::cfg_t        cfg_q;
  kmrb_pkg::cmd_t        cmd;
  kmrb_pkg::front_stat_t fr_stat;
  kmrb_pkg::back_stat_t  bk_stat;
  logic                  cmd_valid, cmd_pop;
  logic                  reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lower_add <= 2'd1;
      cfg_q.raise_add <= 2'd2;
    end else if (reg_wr) begin
      case (paddr[2])
        kmrb_pkg::REG_LOWER_ADD: cfg_q.lower_add <= pwdata[1:0];
        kmrb_pkg::REG_RAISE_ADD: cfg_q.raise_add <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      kmrb_pkg::REG_LOWER_ADD: prdata = {30'd0, cfg_q.lower_add};
      kmrb_pkg::REG_RAISE_ADD: prdata = {30'd0, cfg_q.raise_add};
      default:                 prdata = 32'd0;
    endcase
  end

  kmrb_front #(
    .ROWS   (ROWS),
    .COLS   (COLS),
    .LAYERS (LAYERS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg_q),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .stat_o      (fr_stat)
  );

  kmrb_back #(
    .ROWS   (ROWS),
    .COLS   (COLS),
    .SLOTS  (SLOTS),
    .LAYERS (LAYERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .stat_o      (bk_stat)
  );

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.pop |-> fr_stat.count != 2'd0)
    else $error("command popped from empty queue");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_stat.count <= 2'(kmrb_pkg::QUEUE_DEPTH))
    else $error("command queue overfilled");

  a_report_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(bk_stat.emit))
    else $error("report shown without emit");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.pop |-> !bk_stat.busy)
    else $error("command popped while sequencer busy");
`endif

endmodule

>>> hdl/kmrb_front.sv
module kmrb_front #(
  parameter int ROWS   = kmrb_pkg::ROWS_DEF,
  parameter int COLS   = kmrb_pkg::COLS_DEF,
  parameter int LAYERS = kmrb_pkg::LAYERS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  kmrb_pkg::in_item_t    in_item_i,
  input  kmrb_pkg::cfg_t        cfg_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_pop_i,
  output kmrb_pkg::cmd_t        cmd_o,
  output kmrb_pkg::front_stat_t stat_o
);

  localparam int ROWS_E = (ROWS < 8) ? ROWS : 8;
  localparam int COLS_E = (COLS < 8) ? COLS : 8;

  kmrb_pkg::cmd_t cls;
  logic           col_ok;
  logic [2:0]     sum;
  logic [7:0]     row_keep;
  logic           push;

  kmrb_pkg::cmd_t entry_q [kmrb_pkg::QUEUE_DEPTH];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q, count_d;

  always_comb begin
    col_ok = {1'b0, in_item_i.col_index} < 4'(COLS_E);
    sum = 3'd0;
    if (in_item_i.lower_held) sum = sum + {1'b0, cfg_i.lower_add};
    if (in_item_i.raise_held) sum = sum + {1'b0, cfg_i.raise_add};
    if (sum > 3'(LAYERS - 1)) sum = 3'(LAYERS - 1);
    for (int r = 0; r < 8; r++) begin
      row_keep[r] = (r < ROWS_E);
    end

    cls.cmd   = in_item_i.action ? kmrb_pkg::CMD_SCAN : kmrb_pkg::CMD_WRITE;
    cls.wen   = col_ok && ({1'b0, in_item_i.map_layer} < 3'(LAYERS))
                && ({1'b0, in_item_i.map_row} < 4'(ROWS_E));
    cls.layer = in_item_i.action ? sum[1:0] : in_item_i.map_layer;
    cls.row   = in_item_i.map_row;
    cls.col   = in_item_i.col_index;
    cls.code  = in_item_i.entry_code;
    cls.mask  = col_ok ? (in_item_i.row_bits & row_keep) : 8'd0;
    cls.first = in_item_i.first_column;
    cls.last  = in_item_i.last_column;
  end

  assign in_stall_o = (count_q == 2'(kmrb_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    count_d = count_q;
    if (push && !cmd_pop_i) count_d = count_q + 2'd1;
    else if (!push && cmd_pop_i) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= cls;
  end

  assign cmd_valid_o  = (count_q != 2'd0);
  assign cmd_o        = entry_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.full  = in_stall_o;

endmodule

>>> hdl/kmrb_back.sv
module kmrb_back #(
  parameter int ROWS   = kmrb_pkg::ROWS_DEF,
  parameter int COLS   = kmrb_pkg::COLS_DEF,
  parameter int SLOTS  = kmrb_pkg::SLOTS_DEF,
  parameter int LAYERS = kmrb_pkg::LAYERS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_pop_o,
  input  kmrb_pkg::cmd_t       cmd_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output kmrb_pkg::out_item_t  out_item_o,
  output kmrb_pkg::back_stat_t stat_o
);

  localparam int ROWS_E = (ROWS < 8) ? ROWS : 8;
  localparam int COLS_E = (COLS < 8) ? COLS : 8;
  localparam int DEPTH  = LAYERS * ROWS_E * COLS_E;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  kmrb_pkg::state_e state_q, state_d;

  logic [15:0] mem_q [DEPTH];
  logic [15:0] rdata_q;
  logic [7:0]  waddr, raddr;

  logic [2:0]  row_q;
  logic [7:0]  mask_q;
  logic [2:0]  col_q;
  logic        last_q;
  logic [1:0]  layer_q;
  logic        pend_q;
  logic [2:0]  count_q;
  logic [7:0]  mods_q;
  logic [7:0]  slot_q [kmrb_pkg::KEY_FIELDS];
  logic        out_valid_q;
  kmrb_pkg::out_item_t out_q;

  logic pop, mem_we, rd_en, load, emit;

  assign waddr = kmrb_pkg::map_index(cmd_i.layer, cmd_i.row, cmd_i.col, ROWS_E, COLS_E);
  assign raddr = kmrb_pkg::map_index(layer_q, row_q, col_q, ROWS_E, COLS_E);

  always_comb begin
    state_d = state_q;
    pop     = 1'b0;
    mem_we  = 1'b0;
    rd_en   = 1'b0;
    load    = 1'b0;
    emit    = 1'b0;
    case (state_q)
      kmrb_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          pop = 1'b1;
          if (cmd_i.cmd == kmrb_pkg::CMD_WRITE) begin
            mem_we = cmd_i.wen;
          end else begin
            load    = 1'b1;
            state_d = kmrb_pkg::ST_SCAN;
          end
        end
      end
      kmrb_pkg::ST_SCAN: begin
        rd_en = mask_q[row_q];
        if (row_q == 3'(ROWS_E - 1)) state_d = kmrb_pkg::ST_DRAIN;
      end
      kmrb_pkg::ST_DRAIN: begin
        state_d = last_q ? kmrb_pkg::ST_EMIT : kmrb_pkg::ST_IDLE;
      end
      kmrb_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          emit    = 1'b1;
          state_d = kmrb_pkg::ST_IDLE;
        end
      end
      default: state_d = kmrb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kmrb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr[AW-1:0]] <= cmd_i.code;
    if (rd_en) rdata_q <= mem_q[raddr[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= 3'd0;
      mask_q      <= 8'd0;
      col_q       <= 3'd0;
      last_q      <= 1'b0;
      layer_q     <= 2'd0;
      pend_q      <= 1'b0;
      count_q     <= 3'd0;
      mods_q      <= 8'd0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < kmrb_pkg::KEY_FIELDS; k++) slot_q[k] <= 8'd0;
    end else begin
      pend_q <= rd_en;
      if (load) begin
        row_q  <= 3'd0;
        mask_q <= cmd_i.mask;
        col_q  <= cmd_i.col;
        last_q <= cmd_i.last;
        if (cmd_i.first) begin
          layer_q <= cmd_i.layer;
          count_q <= 3'd0;
          mods_q  <= 8'd0;
          for (int k = 0; k < kmrb_pkg::KEY_FIELDS; k++) slot_q[k] <= 8'd0;
        end
      end else if (state_q == kmrb_pkg::ST_SCAN) begin
        row_q <= row_q + 3'd1;
      end
      // collect the entry read in the previous cycle
      if (pend_q && (count_q < 3'(SLOTS))) begin
        slot_q[count_q] <= rdata_q[7:0];
        count_q         <= count_q + 3'd1;
        mods_q          <= mods_q | rdata_q[15:8];
      end
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.modifiers <= mods_q;
      out_q.key_0     <= slot_q[0];
      out_q.key_1     <= slot_q[1];
      out_q.key_2     <= slot_q[2];
      out_q.key_3     <= slot_q[3];
      out_q.key_4     <= slot_q[4];
      out_q.key_5     <= slot_q[5];
    end
  end

  assign cmd_pop_o   = pop;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign stat_o.pop  = pop;
  assign stat_o.emit = emit;
  assign stat_o.busy = (state_q != kmrb_pkg::ST_IDLE);

endmodule
